// ----- src/tmr16_pkg.sv -----
// ----------------------------------------------------------------------------
// tmr16_pkg
// Shared types, register map and bit positions for the prescaled 16-bit timer.
// ----------------------------------------------------------------------------
package tmr16_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // Register map.
  typedef enum logic [1:0] {
    ADDR_CNT_LO = 2'd0,
    ADDR_CNT_HI = 2'd1,
    ADDR_CTRL   = 2'd2,
    ADDR_FLAG   = 2'd3
  } addr_t;

  // Control byte bit positions.
  localparam int unsigned CTRL_RD16_BIT = 7;
  localparam int unsigned CTRL_PS_HI    = 5;
  localparam int unsigned CTRL_PS_LO    = 4;
  localparam int unsigned CTRL_SRC_BIT  = 1;
  localparam int unsigned CTRL_RUN_BIT  = 0;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned PS_W        = 3;

  // One result item.
  typedef struct packed {
    logic       irq;
    logic       overflow_flag;
    logic [7:0] rdata;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // Prescaler ratio 1/2/4/8, one wider than the prescale counter.
  function automatic logic [PS_W:0] prescale_ratio(input logic [1:0] sel);
    logic [PS_W:0] r;
    case (sel)
      2'd0:    r = (PS_W+1)'(1);
      2'd1:    r = (PS_W+1)'(2);
      2'd2:    r = (PS_W+1)'(4);
      default: r = (PS_W+1)'(8);
    endcase
    return r;
  endfunction

endpackage

// ----- src/timer16_prescaled_rd16_core.sv -----
// ----------------------------------------------------------------------------
// timer16_prescaled_rd16_core
// 16-bit timer with 1/2/4/8 prescaler, byte bus access and RD16 buffering.
// ----------------------------------------------------------------------------
//  channel | dir | ports                 | contents
//  in      | in  | in_tvalid/tready/...  | tuser op; tdata addr, wdata, tick_external
//  out     | out | out_tvalid/tready/... | tdata rdata, overflow_flag, irq
//
// One item per cycle while in_tready is high: timer state updates in the cycle an
// item is taken; its result goes to the result register, shown in the following
// cycle, if that is free or drains, else to the skid register. This two-entry stage
// keeps taking items while out_tready is low; in_tready drops once both are full.
// Reset (rst_n low, synchronous) clears all timer state and empties the output.
module timer16_prescaled_rd16_core
  import tmr16_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] reg_addr, [9:2] wdata,
                                             // [10] tick_external, rest zero
  input  logic [1:0]             in_tuser,   // [1:0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [7:0] rdata, [8] overflow_flag,
                                             // [9] irq, rest zero
);

  // Timer state.
  logic [15:0]     count_r,    count_nxt;
  logic [7:0]      hbuf_r,     hbuf_nxt;
  logic [7:0]      ctrl_r,     ctrl_nxt;
  logic [PS_W-1:0] ps_cnt_r,   ps_cnt_nxt;
  logic            flag_r,     flag_nxt;
  logic            irq_en_r,   irq_en_nxt;

  // Output stage.
  result_t main_r, skid_r, res;
  logic    main_vld_r, skid_vld_r;

  op_t        op;
  addr_t      addr;
  logic [7:0] wdata;
  logic       tick_ext;
  logic       push, pop;
  logic       rd16;
  logic [PS_W:0] ps_next;
  logic [7:0] rd;

  assign op       = op_t'(in_tuser);
  assign addr     = addr_t'(in_tdata[1:0]);
  assign wdata    = in_tdata[9:2];
  assign tick_ext = in_tdata[10];

  assign in_tready = !skid_vld_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = main_vld_r && out_tready;
  assign rd16      = ctrl_r[CTRL_RD16_BIT];
  assign ps_next   = {1'b0, ps_cnt_r} + (PS_W+1)'(1);

  always_comb begin
    count_nxt  = count_r;
    hbuf_nxt   = hbuf_r;
    ctrl_nxt   = ctrl_r;
    ps_cnt_nxt = ps_cnt_r;
    flag_nxt   = flag_r;
    irq_en_nxt = irq_en_r;
    rd         = 8'd0;
    case (op)
      OP_READ: begin
        unique case (addr)
          ADDR_CNT_LO: begin
            rd = count_r[7:0];
            if (rd16) hbuf_nxt = count_r[15:8];
          end
          ADDR_CNT_HI: rd = rd16 ? hbuf_r : count_r[15:8];
          ADDR_CTRL:   rd = ctrl_r;
          default:     rd = {6'd0, irq_en_r, flag_r};
        endcase
      end
      OP_WRITE: begin
        unique case (addr)
          ADDR_CNT_LO: begin
            count_nxt  = {(rd16 ? hbuf_r : count_r[15:8]), wdata};
            ps_cnt_nxt = '0;
          end
          ADDR_CNT_HI: begin
            if (rd16) hbuf_nxt = wdata;
            else      count_nxt = {wdata, count_r[7:0]};
            ps_cnt_nxt = '0;
          end
          ADDR_CTRL:   ctrl_nxt = wdata;
          default: begin
            flag_nxt   = wdata[0];
            irq_en_nxt = wdata[1];
          end
        endcase
      end
      OP_TICK: begin
        if (ctrl_r[CTRL_RUN_BIT] && (ctrl_r[CTRL_SRC_BIT] == tick_ext)) begin
          if (ps_next >= prescale_ratio(ctrl_r[CTRL_PS_HI:CTRL_PS_LO])) begin
            ps_cnt_nxt = '0;
            count_nxt  = count_r + 16'd1;
            if (count_r == 16'hFFFF) flag_nxt = 1'b1;
          end else begin
            ps_cnt_nxt = ps_next[PS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    res.rdata         = rd;
    res.overflow_flag = flag_nxt;
    res.irq           = flag_nxt && irq_en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      hbuf_r   <= '0;
      ctrl_r   <= '0;
      ps_cnt_r <= '0;
      flag_r   <= 1'b0;
      irq_en_r <= 1'b0;
    end else if (push) begin
      count_r  <= count_nxt;
      hbuf_r   <= hbuf_nxt;
      ctrl_r   <= ctrl_nxt;
      ps_cnt_r <= ps_cnt_nxt;
      flag_r   <= flag_nxt;
      irq_en_r <= irq_en_nxt;
    end
  end

  // When the skid register holds an item, no new item is taken, so it only drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (main_vld_r && !pop) skid_vld_r <= 1'b1;
      else                    main_vld_r <= 1'b1;
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (main_vld_r && !pop) skid_r <= res;
      else                    main_r <= res;
    end
  end

  assign out_tvalid = main_vld_r;
  assign out_tdata  = {(OUT_TDATA_W-RESULT_W)'(0), main_r};

endmodule

// ----- src/tmr16_checker.sv -----
// ----------------------------------------------------------------------------
// tmr16_checker
// Port-level checks for the prescaled 16-bit timer, bound to the top level.
// ----------------------------------------------------------------------------
module tmr16_checker
  import tmr16_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A held result must not change while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The interrupt request can only be up while the overflow flag is set.
  a_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8])
    else $error("irq without overflow flag");

  // The input side only stalls when results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with output empty");

  // An item accepted into an idle block shows its result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> out_tvalid)
    else $error("result missing one cycle after accept");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind timer16_prescaled_rd16_core tmr16_checker u_tmr16_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/timer16_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer16_checker
// Watches both streams of the timer core. It keeps its own copy of the timer
// state, works out the result of every accepted item, and compares each
// accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module timer16_checker
  import tmr16_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     pending,
  output int                     errors
);

  // Timer state as seen from the bus.
  logic [15:0]     tm_count;
  logic [7:0]      tm_hbuf;
  logic [7:0]      tm_ctrl;
  logic [PS_W-1:0] tm_ps;
  logic            tm_flag;
  logic            tm_irq_en;

  result_t timer_results_q[$];
  int      err_cnt;

  initial begin
    pending = 0;
    errors  = 0;
    err_cnt = 0;
  end

  task automatic advance_timer(input op_t op, input addr_t addr, input logic [7:0] wd,
                               input logic ext, output result_t res);
    logic       rd16;
    logic [3:0] ratio;
    rd16 = tm_ctrl[CTRL_RD16_BIT];
    res  = '0;
    case (op)
      OP_READ: begin
        case (addr)
          ADDR_CNT_LO: begin
            res.rdata = tm_count[7:0];
            if (rd16) tm_hbuf = tm_count[15:8];
          end
          ADDR_CNT_HI: res.rdata = rd16 ? tm_hbuf : tm_count[15:8];
          ADDR_CTRL:   res.rdata = tm_ctrl;
          default:     res.rdata = {6'd0, tm_irq_en, tm_flag};
        endcase
      end
      OP_WRITE: begin
        case (addr)
          ADDR_CNT_LO: begin
            tm_count = {rd16 ? tm_hbuf : tm_count[15:8], wd};
            tm_ps    = '0;
          end
          ADDR_CNT_HI: begin
            if (rd16) tm_hbuf = wd;
            else tm_count[15:8] = wd;
            tm_ps = '0;
          end
          ADDR_CTRL: tm_ctrl = wd;
          default: begin
            tm_flag   = wd[0];
            tm_irq_en = wd[1];
          end
        endcase
      end
      OP_TICK: begin
        if (tm_ctrl[CTRL_RUN_BIT] && (tm_ctrl[CTRL_SRC_BIT] == ext)) begin
          ratio = 4'd1 << tm_ctrl[CTRL_PS_HI:CTRL_PS_LO];
          // A shrunk prescaler may leave the count at or above the ratio;
          // the next counted tick then advances the counter.
          if ({1'b0, tm_ps} + 4'd1 >= ratio) begin
            tm_ps = '0;
            if (tm_count == 16'hFFFF) tm_flag = 1'b1;
            tm_count = tm_count + 16'd1;
          end else begin
            tm_ps = tm_ps + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.overflow_flag = tm_flag;
    res.irq           = tm_flag & tm_irq_en;
  endtask

  always @(posedge clk) begin
    result_t exp_res;
    result_t got_res;
    if (!rst_n) begin
      tm_count  = '0;
      tm_hbuf   = '0;
      tm_ctrl   = '0;
      tm_ps     = '0;
      tm_flag   = 1'b0;
      tm_irq_en = 1'b0;
      timer_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = result_t'(out_tdata[RESULT_W-1:0]);
        if (timer_results_q.size() == 0) begin
          $display("%0t: result item with none expected: actual %h", $time, out_tdata);
          err_cnt++;
        end else begin
          exp_res = timer_results_q.pop_front();
          if (got_res.rdata !== exp_res.rdata) begin
            $display("%0t: rdata mismatch: expected %h, actual %h",
                     $time, exp_res.rdata, got_res.rdata);
            err_cnt++;
          end
          if (got_res.overflow_flag !== exp_res.overflow_flag) begin
            $display("%0t: overflow_flag mismatch: expected %b, actual %b",
                     $time, exp_res.overflow_flag, got_res.overflow_flag);
            err_cnt++;
          end
          if (got_res.irq !== exp_res.irq) begin
            $display("%0t: irq mismatch: expected %b, actual %b",
                     $time, exp_res.irq, got_res.irq);
            err_cnt++;
          end
          if (out_tdata[OUT_TDATA_W-1:RESULT_W] !== '0) begin
            $display("%0t: tdata padding mismatch: expected 0, actual %h",
                     $time, out_tdata[OUT_TDATA_W-1:RESULT_W]);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_timer(op_t'(in_tuser), addr_t'(in_tdata[1:0]), in_tdata[9:2],
                      in_tdata[10], exp_res);
        timer_results_q.push_back(exp_res);
      end
    end
    pending <= timer_results_q.size();
    errors  <= err_cnt;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus reads, bus writes and clock ticks into the prescaled timer core,
// with random gaps and receiver stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tmr16_pkg::*;

  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned LONG_HOLD   = 300;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     pending;
  int                     errors;

  int unsigned items_sent   = 0;
  int unsigned no_gap_left  = 0;
  int unsigned hold_reqs    = 0;
  logic [7:0]  cur_ctrl     = 8'h00;

  timer16_prescaled_rd16_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  timer16_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .errors     (errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly no gap, sometimes a short one, rarely a long one, and now and
  // then a stretch with no gaps at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 97) begin
      no_gap_left = $urandom_range(50, 150);
      return 0;
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input op_t op, input addr_t addr, input logic [7:0] wd,
                           input logic ext);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, ext, wd, addr};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == OP_WRITE && addr == ADDR_CTRL) cur_ctrl = wd;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic bus_wr(input addr_t addr, input logic [7:0] wd);
    send_item(OP_WRITE, addr, wd, 1'($urandom_range(0, 1)));
  endtask

  task automatic bus_rd(input addr_t addr);
    send_item(OP_READ, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic tick(input logic ext);
    send_item(OP_TICK, addr_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), ext);
  endtask

  // Idle the input and wait until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random ready runs and stalls, plus long hold-offs on request.
  initial begin
    int unsigned hold_served;
    int unsigned run_len;
    int unsigned stall;
    hold_served = 0;
    out_tready  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_tready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
      stall = $urandom_range(0, 99);
      if (stall < 55) stall = 0;
      else if (stall < 95) stall = $urandom_range(1, 3);
      else stall = $urandom_range(10, 40);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    bit          hold_a_done;
    bit          hold_b_done;
    bit          drain_done;
    int unsigned n;
    logic        src;
    logic [7:0]  d;
    op_t         rop;
    hold_a_done = 1'b0;
    hold_b_done = 1'b0;
    drain_done  = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset values, buffered 16-bit access, wrap, shrunk prescaler.
    bus_rd(ADDR_CNT_LO);
    bus_rd(ADDR_CNT_HI);
    bus_rd(ADDR_CTRL);
    bus_rd(ADDR_FLAG);
    bus_wr(ADDR_CTRL, 8'hFF);
    bus_rd(ADDR_CTRL);
    bus_wr(ADDR_FLAG, 8'h03);
    bus_rd(ADDR_FLAG);
    bus_wr(ADDR_FLAG, 8'hFC);
    bus_wr(ADDR_CNT_HI, 8'hFF);
    bus_wr(ADDR_CNT_LO, 8'hFE);
    bus_rd(ADDR_CNT_LO);
    bus_rd(ADDR_CNT_HI);
    bus_wr(ADDR_CTRL, 8'h01);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    bus_wr(ADDR_CTRL, 8'h31);
    repeat (5) tick(1'b0);
    bus_wr(ADDR_CTRL, 8'h11);
    tick(1'b0);
    send_item(OP_UNUSED, ADDR_FLAG, 8'h00, 1'b1);
    bus_wr(ADDR_CNT_HI, 8'h00);

    // Random part: mostly well-formed sequences, some noise.
    while (items_sent < ITEM_TARGET) begin
      if (!hold_a_done && items_sent >= 400) begin
        hold_a_done = 1'b1;
        hold_reqs++;
        no_gap_left = 80;
      end
      if (!drain_done && items_sent >= 1000) begin
        drain_done = 1'b1;
        drain();
      end
      if (!hold_b_done && items_sent >= 1400) begin
        hold_b_done = 1'b1;
        hold_reqs++;
        no_gap_left = 80;
      end
      src = cur_ctrl[CTRL_SRC_BIT];
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 40);
          repeat (n) tick(($urandom_range(0, 4) == 0) ? ~src : src);
        end
        3: begin
          // Load the counter close to the wrap point.
          bus_wr(ADDR_CNT_HI,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'hFF);
          bus_wr(ADDR_CNT_LO, 8'($urandom_range(192, 255)));
        end
        4: begin
          bus_rd(ADDR_CNT_LO);
          bus_rd(ADDR_CNT_HI);
        end
        5: begin
          d = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0) d[CTRL_RUN_BIT] = 1'b1;
          bus_wr(ADDR_CTRL, d);
        end
        6: begin
          bus_wr(ADDR_FLAG, 8'($urandom_range(0, 255)));
          bus_rd(ADDR_FLAG);
        end
        7: bus_rd(addr_t'($urandom_range(0, 3)));
        8: begin
          rop = op_t'($urandom_range(0, 3));
          send_item(rop, addr_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
        default: bus_wr(addr_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      endcase
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
